FILE: rtl/gcga_pkg.sv
// Shared types and constants for the graph bisection fitness and selection block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gcga_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCOUNT_W     = 7;
  localparam int POPULATION   = 4;
  localparam int SLOT_W       = 2;
  localparam int WEIGHT_BITS  = 16;
  localparam int LABEL_BITS   = 4;
  localparam int COST_W       = 32;
  localparam int ROW_W        = POPULATION * LABEL_BITS;

  // Command codes
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_LABEL  = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [VIDX_W-1:0] row_vertex;
    logic [VIDX_W-1:0] col_vertex;
    logic [15:0]       edge_weight;
    logic [SLOT_W-1:0] chrom_slot;
    logic [3:0]        part_label;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] best_slot;
    logic [SLOT_W-1:0] worst_slot;
    logic [COST_W-1:0] best_cost;
    logic [COST_W-1:0] worst_cost;
  } out_item_t;

  // One label row holds the label of one vertex for every population slot.
  typedef logic [ROW_W-1:0] label_row_t;

endpackage

FILE: rtl/graph_cut_ga_reproduction.sv
// Evaluate command: cut accumulation over the n*n matrix, selection, population rebuild,
// then a result strobe on the following cycle (n = vertex count in use). Load commands
// never raise busy; the adjacency memory read port and one matrix entry per cycle set the
// evaluate time. Synchronous reset clears control, sets vertex_count to 64 and makes every
// population label read as zero.
`timescale 1ns / 1ps

module graph_cut_ga_reproduction
  import gcga_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  in_item_t            item,
  input  logic                cfg_wr_en,
  input  logic [VCOUNT_W-1:0] cfg_wr_data,
  output logic                result_valid,
  output out_item_t           result
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_COST   = 2'd1;
  localparam logic [1:0] S_SELECT = 2'd2;
  localparam logic [1:0] S_COPY   = 2'd3;

  // Storage
  logic [WEIGHT_BITS-1:0] adj_mem [MAX_VERTICES*MAX_VERTICES];
  label_row_t             lab_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] lab_valid;

  logic [1:0]          state;
  logic [VCOUNT_W-1:0] vertex_count;
  logic [VIDX_W-1:0]   ci;
  logic [VIDX_W-1:0]   cj;
  logic                acc_en;
  logic [2:0]          sel_cnt;
  logic [VCOUNT_W-1:0] cp;
  logic                wb_pend;
  logic [VIDX_W-1:0]   wb_addr;
  logic [SLOT_W-1:0]   best;
  logic [SLOT_W-1:0]   worst;
  logic [COST_W-1:0]   best_cost;
  logic [COST_W-1:0]   worst_cost;
  logic [COST_W-1:0]   cost_acc [POPULATION];

  // Memory read data
  logic [WEIGHT_BITS-1:0] adj_q;
  label_row_t             lab_a_q;
  label_row_t             lab_b_q;
  logic                   lab_a_v;
  logic                   lab_b_v;

  logic [VCOUNT_W-1:0] n_act;
  logic [VCOUNT_W-1:0] n_m1;
  logic                accept;
  logic                cost_last;
  logic                cp_issue;
  logic [VIDX_W-1:0]   rd_a_addr;
  label_row_t          row_a;
  label_row_t          row_b;
  label_row_t          row_perm;
  label_row_t          lab_wr_row;
  logic [SLOT_W-1:0]   keep_a;
  logic [SLOT_W-1:0]   keep_b;
  logic [SLOT_W-1:0]   sel_slot;
  logic [COST_W-1:0]   sel_cost;
  logic [SLOT_W-1:0]   best_next;
  logic [SLOT_W-1:0]   worst_next;
  logic [COST_W-1:0]   best_cost_next;
  logic [COST_W-1:0]   worst_cost_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Clamp the vertex count to the matrix size
  assign n_act = (vertex_count > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES)
                                                         : vertex_count;
  assign n_m1  = n_act - VCOUNT_W'(1);

  assign cost_last = ({1'b0, ci} == n_m1) && ({1'b0, cj} == n_m1);
  assign cp_issue  = (cp < n_act);
  assign rd_a_addr = (state == S_COPY) ? cp[VIDX_W-1:0] : ci;

  // Rows that were never written read as all-zero labels
  assign row_a = lab_a_v ? lab_a_q : '0;
  assign row_b = lab_b_v ? lab_b_q : '0;

  // Survivors other than best and worst, in slot order
  always_comb begin
    logic found;
    found  = 1'b0;
    keep_a = '0;
    keep_b = '0;
    for (int s = 0; s < POPULATION; s++) begin
      if (SLOT_W'(s) != best && SLOT_W'(s) != worst) begin
        if (!found) begin
          keep_a = SLOT_W'(s);
          found  = 1'b1;
        end else begin
          keep_b = SLOT_W'(s);
        end
      end
    end
  end

  // Rebuilt row: best into slots 0 and 1, survivors into slots 2 and 3
  assign row_perm = {row_a[keep_b*LABEL_BITS +: LABEL_BITS],
                     row_a[keep_a*LABEL_BITS +: LABEL_BITS],
                     row_a[best*LABEL_BITS +: LABEL_BITS],
                     row_a[best*LABEL_BITS +: LABEL_BITS]};

  // Label write into a fresh row: other slots start at zero
  always_comb begin
    lab_wr_row = '0;
    lab_wr_row[item.chrom_slot*LABEL_BITS +: LABEL_BITS] = item.part_label;
  end

  // First-found scan over the four costs, one slot per cycle
  assign sel_slot = SLOT_W'(sel_cnt - 3'd2);
  assign sel_cost = cost_acc[sel_slot];

  always_comb begin
    best_next       = best;
    worst_next      = worst;
    best_cost_next  = best_cost;
    worst_cost_next = worst_cost;
    if (sel_cost < best_cost) begin
      best_next      = sel_slot;
      best_cost_next = sel_cost;
    end else if (sel_cost > worst_cost) begin
      worst_next      = sel_slot;
      worst_cost_next = sel_cost;
    end
    // All costs equal: drop the last slot
    if (sel_cnt == 3'd5 && best_next == worst_next) begin
      worst_next = SLOT_W'(POPULATION - 1);
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VCOUNT_W'(64);
      lab_valid    <= '0;
      acc_en       <= 1'b0;
      wb_pend      <= 1'b0;
      result_valid <= 1'b0;
      ci           <= '0;
      cj           <= '0;
      sel_cnt      <= '0;
      cp           <= '0;
    end else begin
      result_valid <= 1'b0;
      acc_en       <= 1'b0;
      wb_pend      <= 1'b0;
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (accept && item.cmd == CMD_LABEL) begin
            lab_valid[item.row_vertex] <= 1'b1;
          end
          if (accept && item.cmd == CMD_EVAL) begin
            ci      <= '0;
            cj      <= '0;
            sel_cnt <= '0;
            state   <= (n_act == '0) ? S_SELECT : S_COST;
          end
        end
        S_COST: begin
          acc_en <= 1'b1;
          if (cost_last) begin
            sel_cnt <= '0;
            state   <= S_SELECT;
          end else if ({1'b0, cj} == n_m1) begin
            cj <= '0;
            ci <= ci + VIDX_W'(1);
          end else begin
            cj <= cj + VIDX_W'(1);
          end
        end
        S_SELECT: begin
          sel_cnt <= sel_cnt + 3'd1;
          if (sel_cnt == 3'd5) begin
            cp    <= '0;
            state <= S_COPY;
          end
        end
        S_COPY: begin
          if (cp_issue) begin
            cp      <= cp + VCOUNT_W'(1);
            wb_pend <= 1'b1;
          end else if (!wb_pend) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
          if (wb_pend) begin
            lab_valid[wb_addr] <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Adjacency memory: write on load, read one entry per cycle during evaluation
  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_WEIGHT) begin
      adj_mem[{item.row_vertex, item.col_vertex}] <= item.edge_weight;
    end
    adj_q <= adj_mem[{ci, cj}];
  end

  // Label memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (state == S_COPY && wb_pend) begin
      lab_mem[wb_addr] <= row_perm;
    end else if (accept && item.cmd == CMD_LABEL) begin
      if (lab_valid[item.row_vertex]) begin
        lab_mem[item.row_vertex][item.chrom_slot*LABEL_BITS +: LABEL_BITS] <= item.part_label;
      end else begin
        lab_mem[item.row_vertex] <= lab_wr_row;
      end
    end
    lab_a_q <= lab_mem[rd_a_addr];
    lab_b_q <= lab_mem[cj];
    lab_a_v <= lab_valid[rd_a_addr];
    lab_b_v <= lab_valid[cj];
    wb_addr <= cp[VIDX_W-1:0];
  end

  // Cost lanes, selection registers and result payload
  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_EVAL) begin
      for (int s = 0; s < POPULATION; s++) begin
        cost_acc[s] <= '0;
      end
    end else if (acc_en) begin
      // Saturating add of the weight into every slot that cuts this pair
      for (int s = 0; s < POPULATION; s++) begin
        logic [COST_W:0] sum;
        sum = {1'b0, cost_acc[s]} + (COST_W + 1)'(adj_q);
        if (row_a[s*LABEL_BITS +: LABEL_BITS] == '0 &&
            row_b[s*LABEL_BITS +: LABEL_BITS] == LABEL_BITS'(1)) begin
          cost_acc[s] <= sum[COST_W] ? '1 : sum[COST_W-1:0];
        end
      end
    end
    if (state == S_SELECT) begin
      if (sel_cnt == 3'd1) begin
        best       <= '0;
        worst      <= '0;
        best_cost  <= cost_acc[0];
        worst_cost <= cost_acc[0];
      end else if (sel_cnt != 3'd0) begin
        best       <= best_next;
        worst      <= worst_next;
        best_cost  <= best_cost_next;
        worst_cost <= worst_cost_next;
      end
    end
    if (state == S_COPY && !cp_issue && !wb_pend) begin
      result.best_slot  <= best;
      result.worst_slot <= worst;
      result.best_cost  <= best_cost;
      result.worst_cost <= worst_cost;
    end
  end

endmodule

FILE: rtl/gcga_checker.sv
// Port-level checks for the graph bisection block, attached by bind.
// Depends on gcga_pkg and on graph_cut_ga_reproduction.
`timescale 1ns / 1ps

module gcga_checker
  import gcga_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  item,
  input logic      result_valid,
  input out_item_t result
);

  // A result only closes an evaluation that held busy
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a preceding evaluation");

  // One transfer per evaluation
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // Dropped slot never equals the kept best slot
  a_slots_differ: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.best_slot != result.worst_slot)
    else $error("best and worst slot coincide");

  // Best cost never exceeds worst cost
  a_cost_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.best_cost <= result.worst_cost)
    else $error("best cost above worst cost");

  // Evaluate command raises busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_EVAL) |=> busy)
    else $error("evaluate did not start");

endmodule

bind graph_cut_ga_reproduction gcga_checker u_gcga_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
